@@ sv/ostt_pkg.sv @@
// Shared types, codes and constants of the one-shot timer table.
package ostt_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay_ms;
    logic [31:0] timer_id;
    logic [15:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic        is_active;
    logic        table_full;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic latch;
    logic claim;
    logic clear;
    logic rem_wr;
    logic fire;
    logic set_hit;
    logic emit_final;
  } ctl_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       cur_valid;
    logic       id_match;
    logic       expire;
    logic       out_free;
    logic       pend_valid;
  } status_t;

endpackage

@@ sv/ostt_dp.sv @@
// Datapath of the timer table: slot memories, valid bits, id counter, result registers.
module ostt_dp #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  ostt_pkg::cmd_t   cmd,
  input  ostt_pkg::ctl_t   ctl,
  input  logic [IDX_W-1:0] cur,
  input  logic [IDX_W-1:0] rd_addr,
  output ostt_pkg::status_t st,
  output logic             res_valid,
  input  logic             res_ready,
  output ostt_pkg::res_t   res
);
  import ostt_pkg::*;

  logic [31:0] mem_id  [SLOTS];
  logic [31:0] mem_rem [SLOTS];
  logic [31:0] rd_id;
  logic [31:0] rd_rem;
  logic [SLOTS-1:0] slot_valid;
  logic [31:0] next_id;
  cmd_t        cmd_q;
  res_t        pend;
  res_t        pend_last;
  logic        pend_valid;
  logic [31:0] elapsed_ext;
  logic [31:0] new_rem;
  logic        out_load;
  logic        out_free;

  assign elapsed_ext = {16'd0, cmd_q.elapsed_ms};
  assign new_rem     = (rd_rem > elapsed_ext) ? (rd_rem - elapsed_ext) : 32'd0;
  assign out_free    = !res_valid || res_ready;
  assign out_load    = (ctl.fire && pend_valid) || ctl.emit_final;

  assign st.opcode     = cmd_q.opcode;
  assign st.cur_valid  = slot_valid[cur];
  assign st.id_match   = (rd_id == cmd_q.timer_id);
  assign st.expire     = (new_rem == 32'd0);
  assign st.out_free   = out_free;
  assign st.pend_valid = pend_valid;

  always_comb begin
    pend_last             = pend;
    pend_last.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.claim) begin
      mem_id[cur]  <= next_id;
      mem_rem[cur] <= cmd_q.delay_ms;
    end else if (ctl.rem_wr) begin
      mem_rem[cur] <= new_rem;
    end
    rd_id  <= mem_id[rd_addr];
    rd_rem <= mem_rem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_id    <= 32'd0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (ctl.claim) begin
        slot_valid[cur] <= 1'b1;
        next_id         <= next_id + 32'd1;
      end else if (ctl.clear) begin
        slot_valid[cur] <= 1'b0;
      end
      if (ctl.latch) begin
        pend_valid <= (cmd.opcode == OP_START) || (cmd.opcode == OP_QUERY);
      end else if (ctl.fire) begin
        pend_valid <= 1'b1;
      end else if (ctl.emit_final) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q <= cmd;
      if (cmd.opcode == OP_QUERY) begin
        pend <= '{result_kind: KIND_QUERY, result_id: cmd.timer_id, is_active: 1'b0,
                  table_full: 1'b0, last_of_run: 1'b1};
      end else begin
        pend <= '{result_kind: KIND_START, result_id: 32'd0, is_active: 1'b0,
                  table_full: 1'b1, last_of_run: 1'b1};
      end
    end else if (ctl.claim) begin
      pend <= '{result_kind: KIND_START, result_id: next_id, is_active: 1'b0,
                table_full: 1'b0, last_of_run: 1'b1};
    end else if (ctl.set_hit) begin
      pend.is_active <= 1'b1;
    end else if (ctl.fire) begin
      pend <= '{result_kind: KIND_FIRED, result_id: rd_id, is_active: 1'b0,
                table_full: 1'b0, last_of_run: 1'b0};
    end
    if (ctl.emit_final) begin
      res <= pend_last;
    end else if (ctl.fire && pend_valid) begin
      res <= pend;
    end
  end

endmodule

@@ sv/ostt_ctrl.sv @@
// Controller of the timer table: command sequencing and the slot scan.
module ostt_ctrl #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ostt_pkg::status_t st,
  output ostt_pkg::ctl_t    ctl,
  output logic [IDX_W-1:0]  cur,
  output logic [IDX_W-1:0]  rd_addr
);
  import ostt_pkg::*;

  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] cur_next;
  logic [NW-1:0]    n;
  logic [NW-1:0]    n_next;
  logic             last;
  logic             advance;
  logic             hit;
  logic             fire_cond;
  logic             stall;

  assign last      = (cur == IDX_W'(SLOTS - 1));
  assign hit       = st.cur_valid && st.id_match;
  assign fire_cond = st.cur_valid && st.expire && (n < NW'(MAX_RESULTS));
  assign stall     = fire_cond && st.pend_valid && !st.out_free;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cur_next   = cur;
    n_next     = n;
    advance    = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          cur_next   = '0;
          n_next     = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        case (st.opcode)
          OP_START: begin
            if (!st.cur_valid) begin
              ctl.claim  = 1'b1;
              state_next = S_FINISH;
            end else if (last) begin
              state_next = S_FINISH;
            end else begin
              advance = 1'b1;
            end
          end
          OP_STOP: begin
            if (hit) begin
              ctl.clear  = 1'b1;
              state_next = S_FINISH;
            end else if (last) begin
              state_next = S_FINISH;
            end else begin
              advance = 1'b1;
            end
          end
          OP_QUERY: begin
            ctl.set_hit = hit;
            if (last) begin
              state_next = S_FINISH;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            if (!stall) begin
              ctl.rem_wr = st.cur_valid;
              ctl.fire   = fire_cond;
              ctl.clear  = fire_cond;
              if (fire_cond) begin
                n_next = n + NW'(1);
              end
              if (last) begin
                state_next = S_FINISH;
              end else begin
                advance = 1'b1;
              end
            end
          end
        endcase
        if (advance) begin
          cur_next = cur + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          ctl.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = cur_next;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      n     <= n_next;
    end
  end

endmodule

@@ sv/one_shot_timer_table_core.sv @@
// Top level of the one-shot timer table: controller, datapath and checks.
//
//   channel   direction  handshake              payload
//   cmd       in         cmd_valid / cmd_ready  ostt_pkg::cmd_t
//   res       out        res_valid / res_ready  ostt_pkg::res_t
//
// A command is accepted in the idle state, then scanned one slot per cycle while no stall
// holds, as set by the single read port of the slot memories (start and stop end at the
// first free or matching slot), and closed in the finish state. A tick scan that must
// fire a slot and the finish state hold while an earlier transfer waits on res.
// Reset clears all valid bits and the id counter.
// The next command is taken while the last result still waits in res.
module one_shot_timer_table_core #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ostt_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output ostt_pkg::res_t res
);
  import ostt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ctl_t             ctl;
  status_t          st;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] rd_addr;

  ostt_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .st        (st),
    .ctl       (ctl),
    .cur       (cur),
    .rd_addr   (rd_addr)
  );

  ostt_dp #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .cur       (cur),
    .rd_addr   (rd_addr),
    .st        (st),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !st.pend_valid)
    else $error("pending result left behind when idle");

  a_full_is_start: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.table_full) |-> (res.result_id == 32'd0 &&
                                       res.result_kind == KIND_START))
    else $error("table full flag on a bad result");

  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.result_kind == KIND_FIRED) |-> (!res.is_active && !res.table_full))
    else $error("fired result carries stray flags");

  a_claim_excl: assert property (@(posedge clk) disable iff (rst)
    ctl.claim |-> (!ctl.clear && !ctl.rem_wr && !ctl.fire))
    else $error("slot claim overlaps another slot update");

endmodule

@@ test/one_shot_timer_table_core_tb.sv @@
// Self-checking testbench of the one-shot timer table: directed and random commands.
module one_shot_timer_table_core_tb;
  import ostt_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;

  class timer_table_shadow;
    bit          slot_busy[SLOTS];
    logic [31:0] slot_tag[SLOTS];
    logic [31:0] slot_left[SLOTS];
    logic [31:0] id_counter;
    res_t        pending_res[$];
    int          errors;
    int          n_cmds;
    int          n_results;
    int          n_fired;
    int          n_full;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 1'b0;
      end
      id_counter = '0;
      errors = 0;
      n_cmds = 0;
      n_results = 0;
      n_fired = 0;
      n_full = 0;
    endfunction

    function void queue_result(res_t r);
      pending_res = {pending_res, r};
    endfunction

    function void accept_cmd(cmd_t c);
      res_t r;
      int   i;
      int   n;
      bit   hit;
      n_cmds++;
      r = '0;
      hit = 1'b0;
      n = 0;
      case (c.opcode)
        OP_START: begin
          r.result_kind = KIND_START;
          r.last_of_run = 1'b1;
          for (i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i] && !hit) begin
              hit = 1'b1;
              slot_busy[i] = 1'b1;
              slot_tag[i] = id_counter;
              slot_left[i] = c.delay_ms;
              r.result_id = id_counter;
              id_counter = id_counter + 32'd1;
            end
          end
          if (!hit) begin
            r.table_full = 1'b1;
            n_full++;
          end
          queue_result(r);
        end
        OP_STOP: begin
          for (i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_tag[i] == c.timer_id && !hit) begin
              hit = 1'b1;
              slot_busy[i] = 1'b0;
            end
          end
        end
        OP_QUERY: begin
          r.result_kind = KIND_QUERY;
          r.result_id = c.timer_id;
          r.last_of_run = 1'b1;
          for (i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_tag[i] == c.timer_id) begin
              r.is_active = 1'b1;
            end
          end
          queue_result(r);
        end
        default: begin
          for (i = 0; i < SLOTS; i++) begin
            if (slot_busy[i]) begin
              if (slot_left[i] > {16'd0, c.elapsed_ms}) begin
                slot_left[i] = slot_left[i] - {16'd0, c.elapsed_ms};
              end else begin
                slot_left[i] = '0;
              end
              if (slot_left[i] == '0 && n < MAX_RESULTS) begin
                r = '0;
                r.result_kind = KIND_FIRED;
                r.result_id = slot_tag[i];
                queue_result(r);
                slot_busy[i] = 1'b0;
                n++;
              end
            end
          end
          if (n > 0) begin
            r = pending_res.pop_back();
            r.last_of_run = 1'b1;
            queue_result(r);
          end
          n_fired += n;
        end
      endcase
    endfunction

    function void check_res(res_t got);
      res_t want;
      n_results++;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: kind %0d id %h active %b full %b last %b",
                   got.result_kind, got.result_id, got.is_active, got.table_full,
                   got.last_of_run);
        end
        return;
      end
      want = pending_res.pop_front();
      if (got.result_kind !== want.result_kind || got.result_id !== want.result_id ||
          got.is_active !== want.is_active || got.table_full !== want.table_full ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected kind %0d id %h active %b full %b last %b",
                   want.result_kind, want.result_id, want.is_active, want.table_full,
                   want.last_of_run);
          $display("                 actual   kind %0d id %h active %b full %b last %b",
                   got.result_kind, got.result_id, got.is_active, got.table_full,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  timer_table_shadow sb = new();
  int send_idle = 34;
  int recv_idle = 45;

  one_shot_timer_table_core #(.SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        sb.check_res(res);
      end
      res_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [15:0] any_ela();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic cmd_t mk_cmd(logic [1:0] op, logic [31:0] dly, logic [31:0] tid,
                                  logic [15:0] ela);
    cmd_t c;
    c.opcode = op;
    c.delay_ms = dly;
    c.timer_id = tid;
    c.elapsed_ms = ela;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    c = mk_cmd(OP_START, $urandom, $urandom, any_ela());
    if (pick < 35) begin
      if (sub < 10) begin
        c.delay_ms = $urandom;
      end else if (sub < 20) begin
        c.delay_ms = '0;
      end else begin
        c.delay_ms = $urandom_range(1, 300);
      end
    end else if (pick < 55) begin
      c.opcode = OP_TICK;
      if (sub >= 10) begin
        c.elapsed_ms = 16'($urandom_range(0, 100));
      end
    end else begin
      c.opcode = (pick < 75) ? OP_QUERY : OP_STOP;
      if (sub >= 15) begin
        c.timer_id = sb.id_counter - 32'($urandom_range(1, 20));
      end
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.accept_cmd(c);
  endtask

  task automatic drain_hold();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int s_idle, input int r_idle, input int count);
    int k;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (k = 0; k < count; k++) begin
      send_cmd(random_cmd());
      if (k == count / 2) begin
        drain_hold();
      end
    end
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_cmd(mk_cmd(OP_QUERY, $urandom, 32'd0, any_ela()));
    send_cmd(mk_cmd(OP_START, 32'd0, $urandom, any_ela()));
    send_cmd(mk_cmd(OP_START, 32'hFFFF_FFFF, $urandom, any_ela()));
    send_cmd(mk_cmd(OP_QUERY, $urandom, 32'd0, any_ela()));
    send_cmd(mk_cmd(OP_TICK, $urandom, $urandom, 16'd0));
    send_cmd(mk_cmd(OP_QUERY, $urandom, 32'd0, any_ela()));
    send_cmd(mk_cmd(OP_STOP, $urandom, 32'hFFFF_FFFF, any_ela()));
    send_cmd(mk_cmd(OP_STOP, $urandom, 32'd1, any_ela()));
    send_cmd(mk_cmd(OP_QUERY, $urandom, 32'd1, any_ela()));
    for (i = 0; i < SLOTS; i++) begin
      send_cmd(mk_cmd(OP_START, 32'(i * 3), $urandom, any_ela()));
    end
    send_cmd(mk_cmd(OP_START, 32'd7, $urandom, any_ela()));
    send_cmd(mk_cmd(OP_TICK, $urandom, $urandom, 16'hFFFF));
    send_cmd(mk_cmd(OP_TICK, $urandom, $urandom, 16'd50));
    drain_hold();

    random_phase(34, 45, 44);
    random_phase(45, 34, 44);
    random_phase(0, 0, 44);

    cmd_valid <= 1'b0;
    while (sb.pending_res.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    $display("run covered %0d commands and %0d results (%0d fired, %0d table-full starts)",
             sb.n_cmds, sb.n_results, sb.n_fired, sb.n_full);
    $display("mismatches: %0d, results still outstanding: %0d",
             sb.errors, sb.pending_res.size());
    if (sb.errors == 0 && sb.pending_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", sb.pending_res.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ostt_pkg.sv
sv/ostt_dp.sv
sv/ostt_ctrl.sv
sv/one_shot_timer_table_core.sv
test/one_shot_timer_table_core_tb.sv
